/* rtl/hcbp_pkg.sv */
// Package for the Huffman code bit packer.
// Holds the function codes, field widths and the lookup struct shared by all modules.
// Depends on nothing.
package hcbp_pkg;

	localparam int CODE_W = 32;
	localparam int LEN_W  = 6;
	localparam int SYM_W  = 8;
	localparam int BUF_W  = 40;

	typedef logic [1:0] func_t;

	localparam func_t FUNC_LOAD   = 2'd0;
	localparam func_t FUNC_ENCODE = 2'd1;
	localparam func_t FUNC_FLUSH  = 2'd2;

	typedef struct packed {
		logic              valid;
		func_t             func;
		logic              present;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} lookup_t;

endpackage

/* rtl/hcbp_table.sv */
// Code table of the Huffman code bit packer: code memory, present flags and input stage.
// Depends on hcbp_pkg for the function codes and the lookup struct.
module hcbp_table #(
	parameter int MAX_CODE_LEN = 32,
	parameter int SYMBOL_COUNT = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  hcbp_pkg::func_t                func,
	input  logic [hcbp_pkg::SYM_W-1:0]     symbol,
	input  logic [hcbp_pkg::CODE_W-1:0]    code_bits,
	input  logic [hcbp_pkg::LEN_W-1:0]     code_length,
	input  logic                           entry_present,
	input  logic                           advance,
	output hcbp_pkg::lookup_t              lookup
);
	import hcbp_pkg::*;

	localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);

	logic [CODE_W+LEN_W-1:0] code_mem [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] present_q;
	logic [CODE_W+LEN_W-1:0] rd_q;
	logic                    valid_s1;
	func_t                   func_s1;
	logic                    present_s1;

	logic          accept;
	logic          in_range;
	logic [AW-1:0] addr;
	logic [LEN_W-1:0] len_sat;
	logic          wr_en;

	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;
	assign in_range = {1'b0, symbol} < SYM_LIMIT;
	assign addr     = symbol[AW-1:0];
	assign len_sat  = (code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : code_length;
	assign wr_en    = accept && (func == FUNC_LOAD) && in_range;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			code_mem[addr] <= {len_sat, code_bits};
		end
		if (accept) begin
			rd_q <= code_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q  <= '0;
			valid_s1   <= 1'b0;
			func_s1    <= FUNC_LOAD;
			present_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				present_q[addr] <= entry_present;
			end
			if (accept) begin
				valid_s1   <= 1'b1;
				func_s1    <= func;
				present_s1 <= in_range && present_q[addr];
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign lookup.valid   = valid_s1;
	assign lookup.func    = func_s1;
	assign lookup.present = present_s1;
	assign lookup.code    = rd_q[CODE_W-1:0];
	assign lookup.len     = rd_q[CODE_W+LEN_W-1:CODE_W];

	a_adv_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> valid_s1)
		else $error("stage advanced without an item");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(func_s1) && $stable(present_s1)
			&& (!present_s1 || $stable(rd_q))))
		else $error("stalled lookup changed");
	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> !accept)
		else $error("item accepted while stage stalled");

endmodule

/* rtl/hcbp_packer.sv */
// Bit packer of the Huffman code bit packer: accumulator, byte buffer and output register.
// Depends on hcbp_pkg for the function codes and the lookup struct.
module hcbp_packer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hcbp_pkg::lookup_t          lookup,
	output logic                       advance,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 out_byte,
	output logic                       out_last
);
	import hcbp_pkg::*;

	logic [7:0]       acc_q;
	logic [2:0]       pend_q;
	logic [BUF_W-1:0] buf_q;
	logic [2:0]       cnt_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	logic             buf_mv;
	logic [LEN_W-1:0] shamt;
	logic [CODE_W-1:0] left_code;
	logic [BUF_W-1:0] combined;
	logic [BUF_W-1:0] shifted;
	logic [LEN_W-1:0] total;
	logic [2:0]       full;
	logic             do_encode;
	logic             do_flush;

	assign buf_mv  = (cnt_q != 3'd0) && (!out_valid_q || out_ready);
	assign advance = lookup.valid && ((cnt_q == 3'd0) || ((cnt_q == 3'd1) && buf_mv));

	assign shamt     = LEN_W'(CODE_W) - lookup.len;
	assign left_code = lookup.code << shamt;
	assign combined  = {acc_q, {CODE_W{1'b0}}} | ({left_code, 8'h00} >> pend_q);
	assign total     = {3'b000, pend_q} + lookup.len;
	assign full      = total[5:3];
	assign shifted   = combined << {full, 3'b000};

	assign do_encode = advance && (lookup.func == FUNC_ENCODE) && lookup.present;
	assign do_flush  = advance && (lookup.func == FUNC_FLUSH) && (pend_q != 3'd0);

	always_ff @(posedge clk) begin
		if (do_encode) begin
			buf_q <= combined;
		end else if (do_flush) begin
			buf_q <= {acc_q, {CODE_W{1'b0}}};
		end else if (buf_mv) begin
			buf_q <= buf_q << 8;
		end
		if (buf_mv) begin
			out_byte_q <= buf_q[BUF_W-1 -: 8];
			out_last_q <= (cnt_q == 3'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= 8'h00;
			pend_q      <= 3'd0;
			cnt_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_encode) begin
				acc_q  <= shifted[BUF_W-1 -: 8];
				pend_q <= total[2:0];
				cnt_q  <= full;
			end else if (do_flush) begin
				acc_q  <= 8'h00;
				pend_q <= 3'd0;
				cnt_q  <= 3'd1;
			end else if (buf_mv) begin
				cnt_q <= cnt_q - 3'd1;
			end
			if (buf_mv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("byte buffer count out of range");
	a_acc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q & (8'hFF >> pend_q)) == 8'h00)
		else $error("accumulator holds bits past the pending count");
	a_pack_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> ((cnt_q == 3'd0) || ((cnt_q == 3'd1) && buf_mv)))
		else $error("buffer overwritten before it drained");

endmodule

/* rtl/huffman_code_bit_packer_unit.sv */
// Huffman code bit packer, top level.
// Input words carry a function in tuser: load a code table entry, encode a
// symbol, or flush the pending bits. Each encode looks up its symbol in the
// code table and appends the code, most significant bit first; every byte
// that fills up leaves on the output channel, and the last byte caused by
// one input word carries tlast. A flush pads pending bits with zeros and
// sends them as one byte; with nothing pending it sends nothing.
// An accepted word reaches its first byte through the table read, the pack
// into the byte buffer and the output register. The block takes one word
// per cycle while each word gives at most one byte and the receiver keeps
// up; a word that gives more bytes holds the next word until its last byte
// leaves the byte buffer, which drains one byte per cycle while unstalled.
// Reset clears the present flags, the accumulator and all valid flags; the
// code memory itself keeps no reset value and needs none.
// When the receiver stalls, the output register holds its byte and the
// buffer and input stage fill, after which s_axis_tready drops.
// Depends on hcbp_pkg, hcbp_table and hcbp_packer.
module huffman_code_bit_packer_unit #(
	parameter int MAX_CODE_LEN = 32,
	parameter int SYMBOL_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// symbol[7:0], code_bits[39:8], code_length[45:40], entry_present[46], zero [47]
	input  logic [47:0] s_axis_tdata,
	// func[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// packed_byte[7:0]
	output logic [7:0]  m_axis_tdata,
	output logic        m_axis_tlast
);
	import hcbp_pkg::*;

	lookup_t lookup;
	logic    advance;

	hcbp_table #(
		.MAX_CODE_LEN(MAX_CODE_LEN),
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_table (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.func         (func_t'(s_axis_tuser)),
		.symbol       (s_axis_tdata[7:0]),
		.code_bits    (s_axis_tdata[39:8]),
		.code_length  (s_axis_tdata[45:40]),
		.entry_present(s_axis_tdata[46]),
		.advance      (advance),
		.lookup       (lookup)
	);

	hcbp_packer u_packer (
		.clk      (clk),
		.arst_n   (arst_n),
		.lookup   (lookup),
		.advance  (advance),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_byte (m_axis_tdata),
		.out_last (m_axis_tlast)
	);

endmodule

/* sim/huffman_code_bit_packer_unit_tb.sv */
// Self-checking testbench for the Huffman code bit packer top level.
// A scoreboard class predicts every output byte from the accepted input words; tasks drive
// the input stream in bursts and an always block stalls the receiver. Depends on hcbp_pkg and the RTL.
`timescale 1ns / 1ps

module huffman_code_bit_packer_unit_tb;
	import hcbp_pkg::*;

	localparam int MAX_CODE_LEN = 32;
	localparam int SYMBOL_COUNT = 256;
	localparam int RANDOM_WORDS = 410;
	localparam func_t FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} packed_byte_t;

	class packer_scoreboard;
		logic [31:0]  code_mem [SYMBOL_COUNT];
		logic [5:0]   len_mem [SYMBOL_COUNT];
		bit           present [SYMBOL_COUNT];
		bit [7:0]     acc;
		int           pend;
		packed_byte_t expected_bytes[$];
		int           failures;

		function new();
			foreach (present[i]) present[i] = 1'b0;
			acc = 8'd0;
			pend = 0;
			failures = 0;
		endfunction

		function void note_word(func_t f, logic [7:0] sym, logic [31:0] code, logic [5:0] len,
				logic pres);
			int n;
			int first;
			first = expected_bytes.size();
			case (f)
				FUNC_LOAD: begin
					if (sym < SYMBOL_COUNT) begin
						n = len;
						if (n > MAX_CODE_LEN) n = MAX_CODE_LEN;
						if (n > 32) n = 32;
						code_mem[sym] = code;
						len_mem[sym] = n[5:0];
						present[sym] = pres;
					end
				end
				FUNC_ENCODE: begin
					if (sym < SYMBOL_COUNT && present[sym]) begin
						n = len_mem[sym];
						if (n > 32) n = 32;
						for (int i = n; i > 0; i--) begin
							if (code_mem[sym][i-1]) acc[7-pend] = 1'b1;
							pend++;
							if (pend == 8) begin
								expected_bytes.push_back('{data: acc, last: 1'b0});
								acc = 8'd0;
								pend = 0;
							end
						end
					end
				end
				FUNC_FLUSH: begin
					if (pend != 0) begin
						expected_bytes.push_back('{data: acc, last: 1'b0});
						acc = 8'd0;
						pend = 0;
					end
				end
				default: ;
			endcase
			if (expected_bytes.size() > first)
				expected_bytes[expected_bytes.size()-1].last = 1'b1;
		endfunction

		function void check_byte(logic [7:0] data, logic last);
			packed_byte_t want;
			if (expected_bytes.size() == 0) begin
				if (failures < 10)
					$display("%0t: unexpected byte %02h last %0b", $realtime, data, last);
				failures++;
			end else begin
				want = expected_bytes.pop_front();
				if (data !== want.data || last !== want.last) begin
					if (failures < 10)
						$display("%0t: byte mismatch, expected %02h last %0b, got %02h last %0b",
							$realtime, want.data, want.last, data, last);
					failures++;
				end
			end
		endfunction

		function int outstanding();
			return expected_bytes.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = FUNC_LOAD;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;

	packer_scoreboard sb = new();

	bit         written [SYMBOL_COUNT];
	logic [7:0] written_syms[$];
	int         burst_left = 0;
	int         rx_mode = 0;
	int         rx_left = 0;
	int         rx_phase = 0;

	huffman_code_bit_packer_unit #(
		.MAX_CODE_LEN(MAX_CODE_LEN),
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// The receiver switches at random between four ready patterns of its own.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(20, 150);
		end else begin
			rx_left <= rx_left - 1;
		end
		rx_phase <= rx_phase + 1;
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 9) < 7);
			2: m_axis_tready <= ((rx_phase % 16) >= 12);
			default: m_axis_tready <= ((rx_phase % 32) >= 30);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_byte(m_axis_tdata, m_axis_tlast);
	end

	task automatic send_word(input func_t f, input logic [7:0] sym, input logic [31:0] code,
			input logic [5:0] len, input logic pres);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= f;
		s_axis_tdata <= {1'b0, pres, len, code, sym};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_word(f, sym, code, len, pres);
		if (f == FUNC_LOAD && !written[sym]) begin
			written[sym] = 1'b1;
			written_syms.push_back(sym);
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			burst_left = $urandom_range(0, 40);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_random_word();
		int         pick;
		int         len_pick;
		func_t      f;
		logic [7:0] sym;
		logic [5:0] len;
		pick = $urandom_range(0, 99);
		len_pick = $urandom_range(0, 9);
		if (pick < 22) f = FUNC_LOAD;
		else if (pick < 82) f = FUNC_ENCODE;
		else if (pick < 94) f = FUNC_FLUSH;
		else f = FUNC_UNUSED;
		if (f == FUNC_LOAD)
			sym = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, 31));
		else
			sym = written_syms[$urandom_range(0, written_syms.size() - 1)];
		if (len_pick < 7) len = 6'($urandom_range(1, 12));
		else if (len_pick < 9) len = 6'($urandom_range(13, 32));
		else len = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
		send_word(f, sym, $urandom, len, $urandom_range(0, 7) != 0);
	endtask

	initial begin
		int waited;
		foreach (written[i]) written[i] = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(FUNC_LOAD, 8'h00, 32'h1234_5678, 6'd0, 1'b1);
		send_word(FUNC_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32, 1'b1);
		send_word(FUNC_LOAD, 8'h55, 32'hAAAA_AAAA, 6'd63, 1'b1);
		send_word(FUNC_LOAD, 8'h01, 32'h0000_0001, 6'd1, 1'b1);
		send_word(FUNC_LOAD, 8'h02, 32'h0000_005A, 6'd7, 1'b1);
		send_word(FUNC_LOAD, 8'h03, 32'h0000_001F, 6'd5, 1'b0);
		send_word(FUNC_LOAD, 8'h80, 32'h0000_00A5, 6'd8, 1'b1);
		send_word(FUNC_ENCODE, 8'h00, 32'h0, 6'd0, 1'b0);
		send_word(FUNC_FLUSH, 8'h01, 32'h0, 6'd0, 1'b0);
		send_word(FUNC_ENCODE, 8'h01, 32'h0, 6'd0, 1'b0);
		send_word(FUNC_FLUSH, 8'h01, 32'h0, 6'd0, 1'b0);
		send_word(FUNC_ENCODE, 8'hFF, 32'h0, 6'd0, 1'b0);
		send_word(FUNC_ENCODE, 8'h02, 32'h0, 6'd0, 1'b0);
		send_word(FUNC_ENCODE, 8'hFF, 32'h0, 6'd0, 1'b0);
		send_word(FUNC_ENCODE, 8'h80, 32'h0, 6'd0, 1'b0);
		send_word(FUNC_ENCODE, 8'h03, 32'h0, 6'd0, 1'b0);
		send_word(FUNC_UNUSED, 8'h01, 32'hFFFF_FFFF, 6'd63, 1'b1);
		send_word(FUNC_ENCODE, 8'h55, 32'h0, 6'd0, 1'b0);
		send_word(FUNC_FLUSH, 8'h01, 32'h0, 6'd0, 1'b0);
		send_word(FUNC_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32, 1'b0);
		send_word(FUNC_ENCODE, 8'hFF, 32'h0, 6'd0, 1'b0);
		send_word(FUNC_LOAD, 8'hFF, 32'h0000_0000, 6'd40, 1'b1);
		send_word(FUNC_ENCODE, 8'hFF, 32'h0, 6'd0, 1'b0);
		send_word(FUNC_FLUSH, 8'h01, 32'h0, 6'd0, 1'b0);

		repeat (RANDOM_WORDS) send_random_word();
		s_axis_tvalid <= 1'b0;

		waited = 0;
		while (sb.outstanding() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);

		if (sb.outstanding() != 0)
			$display("%0d expected bytes never arrived", sb.outstanding());
		if (sb.failures == 0 && sb.outstanding() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
